// ----- rtl/pol_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

   localparam int CAPACITY_DEF = 32;

   localparam int DATA_W = 32;
   localparam int OP_W   = 2;
   localparam int POS_W  = 6;
   localparam int ST_W   = 3;
   localparam int CNT_W_MAX = POS_W + 1;

   // operations
   localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE   = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH   = 2'd2;
   localparam logic [OP_W-1:0] OP_TRAVERSE = 2'd3;

   // result status
   localparam logic [ST_W-1:0] STAT_OK       = 3'd0;
   localparam logic [ST_W-1:0] STAT_BAD_POS  = 3'd1;
   localparam logic [ST_W-1:0] STAT_FULL     = 3'd2;
   localparam logic [ST_W-1:0] STAT_EMPTY    = 3'd3;
   localparam logic [ST_W-1:0] STAT_NOTFOUND = 3'd4;

   // cell commands
   localparam logic [2:0] MODE_HOLD = 3'd0;
   localparam logic [2:0] MODE_INS  = 3'd1;
   localparam logic [2:0] MODE_DEL  = 3'd2;
   localparam logic [2:0] MODE_ROT  = 3'd3;
   localparam logic [2:0] MODE_CMP  = 3'd4;

   // broadcast to every cell
   typedef struct packed {
      logic [2:0]           mode;
      logic [POS_W-1:0]     tgt;       // 0-based target slot
      logic [POS_W-1:0]     last_idx;  // slot of the tail entry
      logic [CNT_W_MAX-1:0] count;
      logic [DATA_W-1:0]    din;       // insert value or search key
   } ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/pol_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pol_cell #(
   parameter int CELL_IDX = 0
) (
   input  wire logic                        clock,
   input  wire pol_pkg::ctrl_type           ctrl,
   input  wire logic [pol_pkg::DATA_W-1:0]  left_val,
   input  wire logic [pol_pkg::DATA_W-1:0]  right_val,
   input  wire logic [pol_pkg::DATA_W-1:0]  head_val,
   output logic      [pol_pkg::DATA_W-1:0]  val,
   output logic      [pol_pkg::DATA_W-1:0]  pick,
   output logic                             match
);

   localparam logic [pol_pkg::POS_W-1:0] IDX = pol_pkg::POS_W'(CELL_IDX);

   logic [pol_pkg::DATA_W-1:0] val_ff, val_in;
   logic                       match_ff, match_in;

   always_comb begin
      val_in   = val_ff;
      match_in = match_ff;
      unique case (ctrl.mode)
         pol_pkg::MODE_INS: begin
            if (IDX > ctrl.tgt) begin
               val_in = left_val;
            end else if (IDX == ctrl.tgt) begin
               val_in = ctrl.din;
            end
         end
         pol_pkg::MODE_DEL: begin
            if (IDX >= ctrl.tgt) begin
               val_in = right_val;
            end
         end
         pol_pkg::MODE_ROT: begin
            // tail slot wraps back to the head
            val_in = (IDX == ctrl.last_idx) ? head_val : right_val;
         end
         pol_pkg::MODE_CMP: begin
            match_in = (val_ff == ctrl.din) && ({1'b0, IDX} < ctrl.count);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      match_ff <= match_in;
   end

   assign val   = val_ff;
   assign match = match_ff;
   assign pick  = (IDX == ctrl.tgt) ? val_ff : '0;

endmodule

`default_nettype wire

// ----- rtl/positional_ordered_list_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake              | Beat contents
// req     | in        | req_valid / req_stall  | operation, position, value
// rsp     | out       | rsp_valid / rsp_stall  | status, data, found_position, last
//
// Insert and delete: the cells from the target slot on shift in the same clock.
// Search: the cells compare and register their match bits, then a priority
// encoder over the match bits forms the position in the S_SEARCH state.
// Traverse: the block enters S_TRAV and sends one beat per stored entry; the chain
// rotates one slot per beat and is back in place after the last one.
// Synchronous reset empties the list; cell contents are not cleared.
// rsp is a registered stage: a stalled beat holds, and req is taken only
// when the block is idle and that stage is free or draining.

module positional_ordered_list_top #(
   parameter int CAPACITY = pol_pkg::CAPACITY_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [pol_pkg::OP_W-1:0]     req_operation,
   input  wire logic [pol_pkg::POS_W-1:0]    req_position,
   input  wire logic signed [pol_pkg::DATA_W-1:0] req_value,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [pol_pkg::ST_W-1:0]     rsp_status,
   output logic signed [pol_pkg::DATA_W-1:0] rsp_data,
   output logic      [pol_pkg::POS_W-1:0]    rsp_found_position,
   output logic                              rsp_last
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_TRAV   = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] trav_ff, trav_in;

   logic                       rsp_valid_ff;
   logic [pol_pkg::ST_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [pol_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [pol_pkg::POS_W-1:0]  rsp_fpos_ff, rsp_fpos_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_load;

   pol_pkg::ctrl_type          ctrl;
   logic [pol_pkg::DATA_W-1:0] cell_val  [CAPACITY];
   logic [pol_pkg::DATA_W-1:0] cell_pick [CAPACITY];
   logic [CAPACITY-1:0]        cell_match;

   logic out_free, accept;
   logic [7:0] pos8, cnt8;
   logic [pol_pkg::DATA_W-1:0] picked;
   logic [pol_pkg::POS_W-1:0]  first_pos;
   logic                       any_match;
   logic                       trav_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   assign pos8 = 8'(req_position);
   assign cnt8 = 8'(count_ff);
   assign trav_last = (CNT_W'(trav_ff + 1'b1) == count_ff);

   // value at the target slot, for delete
   always_comb begin
      picked = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         picked = picked | cell_pick[i];
      end
   end

   // first matching slot from the registered match bits
   always_comb begin
      first_pos = '0;
      any_match = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_match[i] && !any_match) begin
            first_pos = pol_pkg::POS_W'(i + 1);
         end
         any_match = any_match | cell_match[i];
      end
   end

   // cell chain
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [pol_pkg::DATA_W-1:0] left_v, right_v;
      if (g == 0) begin : g_head
         assign left_v = '0;
      end else begin : g_body
         assign left_v = cell_val[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_v = '0;
      end else begin : g_mid
         assign right_v = cell_val[g+1];
      end

      pol_cell #(
         .CELL_IDX (g)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .left_val  (left_v),
         .right_val (right_v),
         .head_val  (cell_val[0]),
         .val       (cell_val[g]),
         .pick      (cell_pick[g]),
         .match     (cell_match[g])
      );
   end

   always_comb begin
      ctrl.mode     = pol_pkg::MODE_HOLD;
      ctrl.tgt      = pol_pkg::POS_W'(req_position - 1'b1);
      ctrl.last_idx = pol_pkg::POS_W'(cnt8 - 8'd1);
      ctrl.count    = pol_pkg::CNT_W_MAX'(count_ff);
      ctrl.din      = req_value;

      state_in      = state_ff;
      count_in      = count_ff;
      trav_in       = trav_ff;
      rsp_load      = 1'b0;
      rsp_status_in = pol_pkg::STAT_OK;
      rsp_data_in   = '0;
      rsp_fpos_in   = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  pol_pkg::OP_INSERT: begin
                     rsp_load = 1'b1;
                     if (req_position == '0) begin
                        rsp_status_in = pol_pkg::STAT_BAD_POS;
                     end else if (count_ff >= CAP_CNT) begin
                        rsp_status_in = pol_pkg::STAT_FULL;
                     end else if (pos8 > cnt8 + 8'd1) begin
                        rsp_status_in = pol_pkg::STAT_BAD_POS;
                     end else begin
                        ctrl.mode = pol_pkg::MODE_INS;
                        count_in  = CNT_W'(count_ff + 1'b1);
                     end
                  end
                  pol_pkg::OP_DELETE: begin
                     rsp_load = 1'b1;
                     if (req_position == '0) begin
                        rsp_status_in = pol_pkg::STAT_BAD_POS;
                     end else if (count_ff == '0) begin
                        rsp_status_in = pol_pkg::STAT_EMPTY;
                     end else if (pos8 > cnt8) begin
                        rsp_status_in = pol_pkg::STAT_BAD_POS;
                     end else begin
                        ctrl.mode   = pol_pkg::MODE_DEL;
                        rsp_data_in = picked;
                        count_in    = CNT_W'(count_ff - 1'b1);
                     end
                  end
                  pol_pkg::OP_SEARCH: begin
                     ctrl.mode = pol_pkg::MODE_CMP;
                     state_in  = S_SEARCH;
                  end
                  pol_pkg::OP_TRAVERSE: begin
                     if (count_ff == '0) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = pol_pkg::STAT_EMPTY;
                     end else begin
                        trav_in  = '0;
                        state_in = S_TRAV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = any_match ? pol_pkg::STAT_OK : pol_pkg::STAT_NOTFOUND;
               rsp_fpos_in   = first_pos;
               state_in      = S_IDLE;
            end
         end
         S_TRAV: begin
            if (out_free) begin
               // head goes out, chain rotates by one slot
               rsp_load    = 1'b1;
               rsp_data_in = cell_val[0];
               rsp_last_in = trav_last;
               ctrl.mode   = pol_pkg::MODE_ROT;
               trav_in     = CNT_W'(trav_ff + 1'b1);
               if (trav_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         trav_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         trav_ff      <= trav_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_fpos_ff   <= rsp_fpos_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_data           = rsp_data_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire
